// ===== src/lrwf_pkg.sv =====
// Package for the linear resampler with fades.
// Holds the command codes, register indexes, fade and phase constants shared by the RTL.
// No dependencies.
package lrwf_pkg;

  localparam int FADE_SH = 9;
  localparam int FADE_LEN = 1 << FADE_SH;
  localparam int FADE_W = FADE_SH + 1;

  localparam int STEP_W = 21;
  localparam int CFG_W = 21;

  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1024);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(1048576);
  localparam logic [STEP_W-1:0] PHASE_ONE = STEP_W'(65536);

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [1:0] REG_RATE_STEP = 2'd0;
  localparam logic [1:0] REG_STEREO = 2'd1;
  localparam logic [1:0] REG_ATTEN = 2'd2;

  localparam logic [8:0] GAIN_FULL = 9'd256;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [14:0] out_sample_t;
  typedef logic [FADE_W-1:0] fade_cnt_t;

endpackage

// ===== src/linear_resampler_with_fades.sv =====
// Top level of the linear resampler with fades.
// Uses lrwf_pkg; one shared 17x17 multiplier under a small sequencer.
//
// Usage:
//   Input channel (in_valid/in_ready) carries a command with one source frame.
//   Output channel (out_valid/out_ready) carries interpolated output frames; the
//   last frame caused by an input transfer has last_of_run set.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Sequencing:
//   A start or stop command and an ignored frame are taken in the idle state; a
//   frame that only becomes the held frame passes through S_FIN. A frame that
//   produces outputs steps through S_K0 to S_K4 for each output frame, because the
//   one multiplier is used four times per output (two interpolations and two gain
//   scalings), and then ends in S_FIN.
//   in_ready is high only while the sequencer is idle.
// Reset:
//   rst clears the playback state and loads the register defaults; the block is
//   stopped until a start command arrives.
// Stalls:
//   A finished output frame waits in the output register; when the receiver
//   stalls, the sequencer holds before loading the next one.
module linear_resampler_with_fades import lrwf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  sample_t           left_in,
  input  sample_t           right_in,
  input  logic              end_of_source,
  output logic              out_valid,
  input  logic              out_ready,
  output out_sample_t       left_out,
  output out_sample_t       right_out,
  output logic              last_of_run
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K0 = 3'd1;
  localparam logic [2:0] S_K1 = 3'd2;
  localparam logic [2:0] S_K2 = 3'd3;
  localparam logic [2:0] S_K3 = 3'd4;
  localparam logic [2:0] S_K4 = 3'd5;
  localparam logic [2:0] S_FIN = 3'd6;

  logic [2:0]        state;
  logic [STEP_W-1:0] rate_step;
  logic              stereo_source;
  logic [3:0]        attenuation_shift;

  logic              playing;
  logic              have_prev;
  logic              stopping;
  sample_t           held_left;
  sample_t           held_right;
  sample_t           new_left;
  sample_t           new_right;
  logic              eos;
  logic [STEP_W-1:0] phase_acc;
  fade_cnt_t         fade_in_left;
  fade_cnt_t         fade_out_left;
  logic [8:0]        gain;
  out_sample_t       val_left;
  out_sample_t       val_right;
  out_sample_t       res_left;
  logic signed [33:0] mp;

  logic [STEP_W-1:0]  step_sat;
  logic [STEP_W-1:0]  phase_next;
  logic               run_last;
  logic               out_free;
  logic               in_xfer;
  logic [8:0]         gain_next;
  logic [FADE_W+7:0]  fade_scaled;
  logic signed [16:0] op_a;
  logic signed [16:0] op_b;
  logic signed [33:0] prod;
  sample_t            interp_base;
  logic signed [17:0] interp_sum;
  logic signed [17:0] interp_sh;
  logic [4:0]         down;

  assign in_ready = (state == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign down = 5'(attenuation_shift) + 5'd1;

  always_comb begin
    if (rate_step < STEP_MIN) begin
      step_sat = STEP_MIN;
    end else if (rate_step > STEP_MAX) begin
      step_sat = STEP_MAX;
    end else begin
      step_sat = rate_step;
    end
    phase_next = phase_acc + step_sat;
    run_last = (phase_next >= PHASE_ONE);
  end

  always_comb begin
    if (stopping) begin
      fade_scaled = {fade_out_left, 8'd0} >> FADE_SH;
      gain_next = fade_scaled[8:0];
    end else if (fade_in_left != '0) begin
      fade_scaled = {fade_in_left, 8'd0} >> FADE_SH;
      gain_next = GAIN_FULL - fade_scaled[8:0];
    end else begin
      fade_scaled = '0;
      gain_next = GAIN_FULL;
    end
  end

  always_comb begin
    unique case (state)
      S_K0: begin
        op_a = 17'(new_left) - 17'(held_left);
        op_b = $signed({1'b0, phase_acc[15:0]});
      end
      S_K1: begin
        op_a = 17'(new_right) - 17'(held_right);
        op_b = $signed({1'b0, phase_acc[15:0]});
      end
      S_K2: begin
        op_a = 17'(val_left);
        op_b = $signed({8'd0, gain});
      end
      default: begin
        op_a = 17'(val_right);
        op_b = $signed({8'd0, gain});
      end
    endcase
    prod = op_a * op_b;
    interp_base = (state == S_K1) ? held_left : held_right;
    interp_sum = 18'(interp_base) + $signed(mp[33:16]);
    interp_sh = interp_sum >>> down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step <= STEP_W'(65536);
      stereo_source <= 1'b0;
      attenuation_shift <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE_STEP: rate_step <= cfg_data[STEP_W-1:0];
        REG_STEREO:    stereo_source <= cfg_data[0];
        REG_ATTEN:     attenuation_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      playing <= 1'b0;
      have_prev <= 1'b0;
      stopping <= 1'b0;
      held_left <= '0;
      held_right <= '0;
      phase_acc <= '0;
      fade_in_left <= '0;
      fade_out_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_K4) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            priority if (cmd == CMD_START) begin
              playing <= 1'b1;
              have_prev <= 1'b0;
              held_left <= '0;
              held_right <= '0;
              phase_acc <= '0;
              fade_in_left <= FADE_W'(FADE_LEN);
              fade_out_left <= '0;
              stopping <= 1'b0;
            end else if (cmd == CMD_STOP) begin
              if (playing && !stopping) begin
                fade_out_left <= FADE_W'(FADE_LEN);
                stopping <= 1'b1;
              end else begin
                playing <= 1'b0;
                stopping <= 1'b0;
              end
            end else if (cmd == CMD_FRAME && playing) begin
              new_left <= left_in;
              new_right <= stereo_source ? right_in : left_in;
              eos <= end_of_source;
              if (have_prev && phase_acc < PHASE_ONE) begin
                state <= S_K0;
              end else begin
                state <= S_FIN;
              end
            end else begin
            end
          end
        end
        S_K0: begin
          gain <= gain_next;
          if (stopping) begin
            if (fade_out_left != '0) begin
              fade_out_left <= fade_out_left - fade_cnt_t'(1);
            end
          end else if (fade_in_left != '0) begin
            fade_in_left <= fade_in_left - fade_cnt_t'(1);
          end
          mp <= prod;
          state <= S_K1;
        end
        S_K1: begin
          val_left <= interp_sh[14:0];
          mp <= prod;
          state <= S_K2;
        end
        S_K2: begin
          val_right <= interp_sh[14:0];
          mp <= prod;
          state <= S_K3;
        end
        S_K3: begin
          res_left <= mp[22:8];
          mp <= prod;
          state <= S_K4;
        end
        S_K4: begin
          if (out_free) begin
            out_valid <= 1'b1;
            left_out <= res_left;
            right_out <= mp[22:8];
            last_of_run <= run_last;
            phase_acc <= phase_next;
            state <= run_last ? S_FIN : S_K0;
          end
        end
        S_FIN: begin
          if (have_prev && phase_acc >= PHASE_ONE) begin
            phase_acc <= phase_acc - PHASE_ONE;
          end
          held_left <= new_left;
          held_right <= new_right;
          have_prev <= 1'b1;
          if (stopping && fade_out_left == '0) begin
            stopping <= 1'b0;
          end
          if ((stopping && fade_out_left == '0) || eos) begin
            playing <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rise_from_k4: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_K4)
    else $error("output became valid outside the output step");

  a_phase_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_K0) |-> (phase_acc < PHASE_ONE))
    else $error("interpolation started with phase at or above one");

  a_fade_bound: assert property (@(posedge clk) disable iff (rst)
    (fade_in_left <= FADE_W'(FADE_LEN)) && (fade_out_left <= FADE_W'(FADE_LEN)))
    else $error("fade counter above fade length");

endmodule

// ===== verif/resampler_checker.sv =====
// Checker for the linear resampler with fades: watches the register port and both channels,
// predicts every output frame and compares each output transfer with the oldest prediction.
// Depends on lrwf_pkg for the port types, command codes, register indexes and constants.
module resampler_checker import lrwf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       cmd,
  input  sample_t          left_in,
  input  sample_t          right_in,
  input  logic             end_of_source,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_sample_t      left_out,
  input  out_sample_t      right_out,
  input  logic             last_of_run,
  output int               mismatches,
  output int               pending,
  output int               items_used,
  output int               frames_checked,
  output int               fades_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_MAX = 64;

  typedef struct packed {
    out_sample_t left;
    out_sample_t right;
    logic        last;
  } out_frame_t;

  out_frame_t expected_frames[$];

  logic [STEP_W-1:0] rate_reg;
  logic              stereo_on;
  logic [3:0]        atten_reg;

  logic              playing;
  logic              has_held;
  sample_t           held_l;
  sample_t           held_r;
  logic [STEP_W-1:0] phase;
  fade_cnt_t         fade_in;
  fade_cnt_t         fade_out;
  logic              fading;

  int err_cnt = 0;
  int used_cnt = 0;
  int checked_cnt = 0;
  int faded_cnt = 0;

  function automatic longint blend(input sample_t a, input sample_t b, input logic [15:0] f);
    longint s;
    s = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f);
    return s >>> 16;
  endfunction

  task automatic absorb(input logic [1:0] c, input sample_t l_in, input sample_t r_in,
                        input logic eos);
    sample_t           nr;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] phase_next;
    int                n;
    int unsigned       down;
    longint            gain;
    longint            lv;
    longint            rv;
    out_frame_t        f;
    nr = stereo_on ? r_in : l_in;
    n = 0;
    case (c)
      CMD_START: begin
        used_cnt++;
        playing = 1'b1;
        has_held = 1'b0;
        held_l = '0;
        held_r = '0;
        phase = '0;
        fade_in = fade_cnt_t'(FADE_LEN);
        fade_out = '0;
        fading = 1'b0;
      end
      CMD_STOP: begin
        used_cnt++;
        if (playing && !fading) begin
          fade_out = fade_cnt_t'(FADE_LEN);
          fading = 1'b1;
        end else begin
          playing = 1'b0;
          fading = 1'b0;
        end
      end
      CMD_FRAME: begin
        if (playing) begin
          used_cnt++;
          if (has_held) begin
            step = rate_reg;
            if (step < STEP_MIN) step = STEP_MIN;
            if (step > STEP_MAX) step = STEP_MAX;
            down = 1 + atten_reg;
            while (phase < PHASE_ONE && n < RUN_MAX) begin
              if (fading) begin
                gain = longint'(fade_out) * 256 / FADE_LEN;
                if (fade_out != 0) fade_out--;
              end else if (fade_in != 0) begin
                gain = 256 - longint'(fade_in) * 256 / FADE_LEN;
                fade_in--;
              end else begin
                gain = 256;
              end
              lv = blend(held_l, l_in, phase[15:0]) >>> down;
              rv = blend(held_r, nr, phase[15:0]) >>> down;
              lv = (lv * gain) >>> 8;
              rv = (rv * gain) >>> 8;
              phase_next = phase + step;
              f.left = out_sample_t'(lv);
              f.right = out_sample_t'(rv);
              f.last = (phase_next >= PHASE_ONE) || (n == RUN_MAX - 1);
              expected_frames.push_back(f);
              n++;
              phase = phase_next;
            end
            if (phase >= PHASE_ONE) phase = phase - PHASE_ONE;
          end
          held_l = l_in;
          held_r = nr;
          has_held = 1'b1;
          if (fading && fade_out == 0) begin
            fading = 1'b0;
            playing = 1'b0;
            faded_cnt++;
          end
          if (eos) playing = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_output();
    out_frame_t want;
    if (expected_frames.size() == 0) begin
      err_cnt++;
      $error("Output transfer with nothing expected: left_out %0d, right_out %0d, last_of_run %0b",
             left_out, right_out, last_of_run);
    end else begin
      want = expected_frames.pop_front();
      checked_cnt++;
      if (left_out !== want.left) begin
        err_cnt++;
        $error("left_out mismatch: expected %0d, actual %0d", want.left, left_out);
      end
      if (right_out !== want.right) begin
        err_cnt++;
        $error("right_out mismatch: expected %0d, actual %0d", want.right, right_out);
      end
      if (last_of_run !== want.last) begin
        err_cnt++;
        $error("last_of_run mismatch: expected %0b, actual %0b", want.last, last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_frames.delete();
      rate_reg = STEP_W'(65536);
      stereo_on = 1'b0;
      atten_reg = 4'd1;
      playing = 1'b0;
      has_held = 1'b0;
      held_l = '0;
      held_r = '0;
      phase = '0;
      fade_in = '0;
      fade_out = '0;
      fading = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RATE_STEP: rate_reg = cfg_data[STEP_W-1:0];
          REG_STEREO: stereo_on = cfg_data[0];
          REG_ATTEN: atten_reg = cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) check_output();
      if (in_valid && in_ready) absorb(cmd, left_in, right_in, end_of_source);
    end
    mismatches <= err_cnt;
    pending <= expected_frames.size();
    items_used <= used_cnt;
    frames_checked <= checked_cnt;
    fades_done <= faded_cnt;
  end

endmodule

// ===== verif/tb_linear_resampler_with_fades.sv =====
// Testbench top for the linear resampler with fades: makes directed and random stimulus,
// varies idling on both channels and gives the verdict.
// Depends on lrwf_pkg, the block linear_resampler_with_fades and resampler_checker.
module tb_linear_resampler_with_fades import lrwf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 2000000;
  localparam int HOLD_CYCLES = 900;
  localparam sample_t S_MIN = 16'sh8000;
  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_NEG1 = 16'shFFFF;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       cmd;
  sample_t          left_in;
  sample_t          right_in;
  logic             end_of_source;
  logic             out_valid;
  logic             out_ready;
  out_sample_t      left_out;
  out_sample_t      right_out;
  logic             last_of_run;

  int mismatches;
  int pending;
  int items_used;
  int frames_checked;
  int fades_done;

  int send_idle;
  int recv_idle;
  int hold_reqs;
  int settings_cnt;
  int cycle_cnt;
  int send_pct[3] = '{28, 65, 0};
  int recv_pct[3] = '{65, 28, 0};

  always #4 clk = ~clk;

  linear_resampler_with_fades u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .left_in(left_in),
    .right_in(right_in),
    .end_of_source(end_of_source),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out(left_out),
    .right_out(right_out),
    .last_of_run(last_of_run)
  );

  resampler_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .left_in(left_in),
    .right_in(right_in),
    .end_of_source(end_of_source),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out(left_out),
    .right_out(right_out),
    .last_of_run(last_of_run),
    .mismatches(mismatches),
    .pending(pending),
    .items_used(items_used),
    .frames_checked(frames_checked),
    .fades_done(fades_done)
  );

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return S_NEG1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send(input logic [1:0] c, input sample_t l, input sample_t r, input logic eos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    left_in <= l;
    right_in <= r;
    end_of_source <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    if ($urandom_range(99) < 6) begin
      send(CMD_UNUSED, rand_sample(), rand_sample(), 1'($urandom_range(1)));
    end
    send(CMD_FRAME, rand_sample(), rand_sample(), $urandom_range(99) < 3);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] step, input logic stereo,
                            input logic [3:0] atten);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_RATE_STEP;
    cfg_data <= step;
    @(posedge clk);
    cfg_index <= REG_STEREO;
    cfg_data <= CFG_W'(stereo);
    @(posedge clk);
    cfg_index <= REG_ATTEN;
    cfg_data <= CFG_W'(atten);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  // A session is a start, a stream of frames, and often a stop with a fade-out tail.
  // Some sessions skip the start or stop twice so that broken sequences show up too.
  task automatic random_session();
    logic [CFG_W-1:0] step;
    logic [3:0]       atten;
    logic             fine_step;
    int               sel;
    int               nframes;
    int               nafter;
    sel = $urandom_range(99);
    if (sel < 35) step = CFG_W'($urandom_range(8192, 1024));
    else if (sel < 65) step = CFG_W'($urandom_range(131072, 32768));
    else if (sel < 80) step = CFG_W'($urandom_range(1048576, 131073));
    else if (sel < 90) step = sel[0] ? CFG_W'(1024) : CFG_W'(1048576);
    else if (sel < 95) step = CFG_W'($urandom_range(1023, 0));
    else step = CFG_W'($urandom_range(2097151, 1048577));
    if ($urandom_range(3) == 0) atten = $urandom_range(1) ? 4'd14 : 4'd0;
    else atten = 4'($urandom_range(14));
    set_config(step, 1'($urandom_range(1)), atten);
    fine_step = (step <= CFG_W'(2048));
    if ($urandom_range(9) != 0) send(CMD_START, rand_sample(), rand_sample(), 1'b0);
    nframes = fine_step ? $urandom_range(12, 2) : $urandom_range(10, 1);
    repeat (nframes) send_frame();
    if ($urandom_range(99) < 60) begin
      send(CMD_STOP, rand_sample(), rand_sample(), 1'($urandom_range(1)));
      nafter = fine_step ? $urandom_range(14, 6) : $urandom_range(5, 1);
      repeat (nafter) send_frame();
      if ($urandom_range(3) == 0) begin
        send(CMD_STOP, rand_sample(), rand_sample(), 1'b0);
        send_frame();
      end
    end
  endtask

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d frames still expected.", cycle_cnt, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int target;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_RATE_STEP;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_FRAME;
    left_in = '0;
    right_in = '0;
    end_of_source = 1'b0;
    hold_reqs = 0;
    settings_cnt = 0;
    send_idle = send_pct[0];
    recv_idle = recv_pct[0];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_config(CFG_W'(65536), 1'b0, 4'd0);
    send(CMD_FRAME, S_MAX, '0, 1'b0);
    send(CMD_UNUSED, S_NEG1, S_NEG1, 1'b1);
    send(CMD_STOP, '0, '0, 1'b0);
    send(CMD_START, '0, '0, 1'b0);
    send(CMD_FRAME, S_MIN, S_MAX, 1'b0);
    send(CMD_FRAME, S_MAX, S_MIN, 1'b0);
    send(CMD_FRAME, '0, S_NEG1, 1'b0);
    send(CMD_FRAME, S_NEG1, '0, 1'b0);

    // Step below the floor: full 64-frame runs while the receiver holds off.
    set_config(CFG_W'(0), 1'b1, 4'd14);
    send(CMD_START, '0, '0, 1'b0);
    send(CMD_FRAME, S_MAX, S_MIN, 1'b0);
    hold_reqs <= hold_reqs + 1;
    send(CMD_FRAME, S_MIN, S_MAX, 1'b0);
    send(CMD_FRAME, S_MAX, S_MAX, 1'b0);
    send(CMD_FRAME, S_MIN, S_MIN, 1'b0);
    send(CMD_STOP, '0, '0, 1'b0);
    send(CMD_FRAME, S_MAX, S_MIN, 1'b0);
    send(CMD_STOP, '0, '0, 1'b0);
    send(CMD_FRAME, S_MAX, S_MAX, 1'b0);

    // Step above the ceiling: phase carries over several frames with no output.
    set_config(CFG_W'(2097151), 1'b1, 4'd0);
    send(CMD_START, '0, '0, 1'b0);
    send(CMD_FRAME, S_MAX, S_MIN, 1'b0);
    send(CMD_FRAME, S_MIN, S_MAX, 1'b0);
    send(CMD_FRAME, S_MAX, S_MAX, 1'b0);
    send(CMD_FRAME, S_MIN, S_MIN, 1'b1);
    send(CMD_FRAME, S_MAX, S_MAX, 1'b0);

    set_config(CFG_W'(1048576), 1'b0, 4'd14);
    send(CMD_START, '0, '0, 1'b0);
    send(CMD_FRAME, S_MIN, '0, 1'b1);
    send(CMD_FRAME, S_MAX, S_MAX, 1'b0);

    for (ph = 0; ph < 3; ph++) begin
      send_idle = send_pct[ph];
      recv_idle <= recv_pct[ph];
      target = items_used + 40;
      while (items_used < target) random_session();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d state-changing input transfers and %0d output frames over %0d settings.",
             items_used, frames_checked, settings_cnt);
    $display("Fade-outs that ran to completion: %0d.", fades_done);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lrwf_pkg.sv
src/linear_resampler_with_fades.sv
verif/resampler_checker.sv
verif/tb_linear_resampler_with_fades.sv
